// ===== rtl/core/spk_pkg.sv =====
// ----------------------------------------------------------------------------
// spk_pkg
// Types, register codes and the long-division step shared by the spark
// color envelope pipeline.
// ----------------------------------------------------------------------------
package spk_pkg;

	localparam int NumChan       = 3;
	localparam int ChanW         = 8;
	localparam int PhaseW        = 16;
	localparam int WordW         = 2 * PhaseW;
	localparam int DivSteps      = PhaseW;
	localparam int StepsPerStage = 2;
	localparam int DivStages     = DivSteps / StepsPerStage;

	localparam logic [PhaseW-1:0] FadeLimitReset = 16'h8000;
	localparam logic [ChanW-1:0]  BaseReset      = 8'hFF;

	// channel order in every per-channel array
	localparam int ChRed   = 0;
	localparam int ChGreen = 1;
	localparam int ChBlue  = 2;

	typedef enum logic [1:0] {
		REG_FADE_LIMIT = 2'd0,
		REG_BASE_RED   = 2'd1,
		REG_BASE_GREEN = 2'd2,
		REG_BASE_BLUE  = 2'd3
	} reg_index_t;

	typedef logic [WordW-1:0] div_word_t;

	typedef struct packed {
		logic [PhaseW-1:0]                 fade_limit;
		logic [NumChan-1:0][ChanW-1:0]     base;
	} cfg_t;

	// upper half of word: partial remainder; lower half: numerator bits
	// still to bring down, with quotient bits shifting in from the right
	typedef struct packed {
		logic [PhaseW-1:0]                 divisor;
		div_word_t [NumChan-1:0]           word;
		logic [NumChan-1:0][PhaseW-1:0]    offset;
	} div_data_t;

	function automatic div_word_t div_step(div_word_t w, logic [PhaseW-1:0] d);
		logic [PhaseW:0] r;
		logic [PhaseW:0] diff;
		div_word_t       res;
		r    = {w[WordW-1:PhaseW], w[PhaseW-1]};
		diff = r - {1'b0, d};
		if (r >= {1'b0, d}) begin
			res = {diff[PhaseW-1:0], w[PhaseW-2:0], 1'b1};
		end else begin
			res = {r[PhaseW-1:0], w[PhaseW-2:0], 1'b0};
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/spk_front.sv =====
// ----------------------------------------------------------------------------
// spk_front
// Folds the phase into a triangle, picks the fade-in or blend-to-white
// segment and forms the dividend of each channel.
// ----------------------------------------------------------------------------
module spk_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [15:0]        phase,
	input  spk_pkg::cfg_t      cfg,
	output logic               valid_s2,
	output spk_pkg::div_data_t data_s2
);
	import spk_pkg::*;

	logic [PhaseW-1:0]              folded;
	logic                           blend;
	logic [PhaseW-1:0]              diff;
	logic [PhaseW-1:0]              divisor;
	logic [NumChan-1:0][PhaseW-1:0] scale;
	logic [NumChan-1:0][PhaseW-1:0] offset;

	logic                           valid_s1;
	logic [PhaseW-1:0]              diff_s1;
	logic [PhaseW-1:0]              divisor_s1;
	logic [NumChan-1:0][PhaseW-1:0] scale_s1;
	logic [NumChan-1:0][PhaseW-1:0] offset_s1;

	div_word_t [NumChan-1:0]        prod;

	always_comb begin
		logic [ChanW-1:0] factor;
		logic [ChanW-1:0] c;
		// upper half mirrors down: (0xFFFF - p) * 2
		folded  = phase[PhaseW-1] ? {~phase[PhaseW-2:0], 1'b0} : {phase[PhaseW-2:0], 1'b0};
		blend   = (folded >= cfg.fade_limit);
		diff    = blend ? (folded - cfg.fade_limit) : folded;
		divisor = blend ? ~cfg.fade_limit : cfg.fade_limit;
		for (int ch = 0; ch < NumChan; ch++) begin
			c          = cfg.base[ch];
			factor     = blend ? ~c : c;
			scale[ch]  = {factor, 8'h00} - {8'h00, factor};
			offset[ch] = blend ? ({c, 8'h00} - {8'h00, c}) : '0;
		end
	end

	always_comb begin
		for (int ch = 0; ch < NumChan; ch++) begin
			prod[ch] = diff_s1 * scale_s1[ch];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1         <= diff;
			divisor_s1      <= divisor;
			scale_s1        <= scale;
			offset_s1       <= offset;
			data_s2.divisor <= divisor_s1;
			data_s2.word    <= prod;
			data_s2.offset  <= offset_s1;
		end
	end

	// both segments keep their divisor nonzero
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> data_s2.divisor != '0)
		else $error("divider entered with zero divisor");

	a_dividend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> data_s2.word[ChRed][WordW-1:PhaseW] < data_s2.divisor)
		else $error("quotient would overflow sixteen bits");

endmodule

// ===== rtl/core/spk_div_stage.sv =====
// ----------------------------------------------------------------------------
// spk_div_stage
// One stage of the pipelined restoring divider: retires two quotient bits
// for every channel against the shared divisor.
// ----------------------------------------------------------------------------
module spk_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  spk_pkg::div_data_t in_data,
	output logic               valid_sd,
	output spk_pkg::div_data_t data_sd
);
	import spk_pkg::*;

	div_data_t nxt;

	always_comb begin
		nxt = in_data;
		for (int ch = 0; ch < NumChan; ch++) begin
			for (int s = 0; s < StepsPerStage; s++) begin
				nxt.word[ch] = div_step(nxt.word[ch], in_data.divisor);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sd <= 1'b0;
		end else if (en) begin
			valid_sd <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_sd <= nxt;
		end
	end

	for (genvar ch = 0; ch < NumChan; ch++) begin : g_chk
		a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
			valid_sd |-> data_sd.word[ch][WordW-1:PhaseW] < data_sd.divisor)
			else $error("partial remainder not below divisor");
	end

endmodule

// ===== rtl/core/spk_back.sv =====
// ----------------------------------------------------------------------------
// spk_back
// Adds the segment offset to each quotient, squares the channel and keeps
// the top byte as the drive value.
// ----------------------------------------------------------------------------
module spk_back (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         in_valid,
	input  spk_pkg::div_data_t                           in_data,
	output logic                                         valid_s12,
	output logic [spk_pkg::NumChan-1:0][spk_pkg::ChanW-1:0] out_s12
);
	import spk_pkg::*;

	logic                           valid_s11;
	logic [NumChan-1:0][PhaseW-1:0] v;
	logic [NumChan-1:0][PhaseW-1:0] v_s11;
	div_word_t [NumChan-1:0]        sq;

	always_comb begin
		for (int ch = 0; ch < NumChan; ch++) begin
			v[ch]  = in_data.word[ch][PhaseW-1:0] + in_data.offset[ch];
			sq[ch] = v_s11[ch] * v_s11[ch];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else if (en) begin
			valid_s11 <= in_valid;
			valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s11 <= v;
			for (int ch = 0; ch < NumChan; ch++) begin
				out_s12[ch] <= sq[ch][WordW-1:WordW-ChanW];
			end
		end
	end

	for (genvar ch = 0; ch < NumChan; ch++) begin : g_chk
		a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
			valid_s11 |-> v_s11[ch] <= 16'hFE01)
			else $error("channel level above full white");
		a_drive_bound: assert property (@(posedge clk) disable iff (!arst_n)
			valid_s12 |-> out_s12[ch] <= 8'hFC)
			else $error("drive value above square of full white");
	end

endmodule

// ===== rtl/core/spark_color_envelope_top.sv =====
// ----------------------------------------------------------------------------
// spark_color_envelope_top
// Spark brightness envelope: phase in, gamma-shaped RGB drive out.
// ----------------------------------------------------------------------------
// One phase request enters every clock unless the pipeline is stalled; the
// sustained rate is one item per cycle outside stalls. The divider retires
// two quotient bits per stage over eight stages, and is framed by two front
// stages (fold/select, dividend multiply) and two back stages (offset add,
// squaring). A stall on the color channel while color_valid is high freezes
// the whole pipeline and is passed back as phase_stall in the same cycle.
// Register writes take effect at once and are meant for an empty pipeline.
// ----------------------------------------------------------------------------
module spark_color_envelope_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	input  logic        phase_valid,
	output logic        phase_stall,
	input  logic [15:0] phase,
	output logic        color_valid,
	input  logic        color_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue
);
	import spk_pkg::*;

	cfg_t                          cfg_q;
	logic                          en;
	logic [DivStages:0]            dv_valid;
	div_data_t                     dv_data [DivStages+1];
	logic [NumChan-1:0][ChanW-1:0] out_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fade_limit <= FadeLimitReset;
			cfg_q.base       <= {NumChan{BaseReset}};
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_FADE_LIMIT: cfg_q.fade_limit     <= wr_data;
				REG_BASE_RED:   cfg_q.base[ChRed]    <= wr_data[ChanW-1:0];
				REG_BASE_GREEN: cfg_q.base[ChGreen]  <= wr_data[ChanW-1:0];
				REG_BASE_BLUE:  cfg_q.base[ChBlue]   <= wr_data[ChanW-1:0];
			endcase
		end
	end

	// hold every stage while the finished color waits
	assign en          = !(color_valid && color_stall);
	assign phase_stall = color_valid && color_stall;

	spk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (phase_valid),
		.phase    (phase),
		.cfg      (cfg_q),
		.valid_s2 (dv_valid[0]),
		.data_s2  (dv_data[0])
	);

	for (genvar k = 0; k < DivStages; k++) begin : g_div
		spk_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (dv_valid[k]),
			.in_data  (dv_data[k]),
			.valid_sd (dv_valid[k+1]),
			.data_sd  (dv_data[k+1])
		);
	end

	spk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid[DivStages]),
		.in_data   (dv_data[DivStages]),
		.valid_s12 (color_valid),
		.out_s12   (out_s12)
	);

	assign out_red   = out_s12[ChRed];
	assign out_green = out_s12[ChGreen];
	assign out_blue  = out_s12[ChBlue];

	a_stall_freezes_div: assert property (@(posedge clk) disable iff (!arst_n)
		(color_valid && color_stall) |=> $stable(dv_valid) && $stable(dv_data[DivStages]))
		else $error("divider advanced during output stall");

endmodule
